// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
// each macro expects clk and rst_n in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CHK_IMPLY(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define CHK_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== sv/bffa_pkg.sv =====
`default_nettype none

package bffa_pkg;

    // request codes
    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // configuration register indexes
    localparam logic REG_MAP_BYTES = 1'b0;

    localparam int          ADDR_W         = 3;
    localparam int          DATA_W         = 32;
    localparam int          CFG_W          = 10;
    localparam logic [9:0]  CFG_RESET      = 10'd512;
    localparam int          ROW_BITS       = 64;
    localparam logic [7:0]  FULL_BYTE      = 8'hFF;
    localparam logic [63:0] ROW_TOP_BIT    = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic        req_type;
        logic [11:0] entry_index;
    } in_word_t;

    typedef struct packed {
        logic [11:0] result_index;
        logic [1:0]  status;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC,
        ST_RELEASE,
        ST_FINISH
    } state_t;

    // position of the first zero bit counted from the msb (0 = bit 7)
    function automatic logic [2:0] first_zero8(input logic [7:0] v);
        logic [2:0] k;
        k = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (!v[i]) begin
                k = 3'(7 - i);
            end
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== sv/bffa_ram.sv =====
`default_nettype none

module bffa_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [AW-1:0]                 wr_addr,
    input  wire logic [bffa_pkg::ROW_BITS-1:0] wr_data,
    input  wire logic                          rd_en,
    input  wire logic [AW-1:0]                 rd_addr,
    output logic      [bffa_pkg::ROW_BITS-1:0] rd_data
);

    logic [bffa_pkg::ROW_BITS-1:0] mem [DEPTH];
    logic [bffa_pkg::ROW_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/bffa_cfg.sv =====
`default_nettype none

module bffa_cfg #(
    parameter int  MAP_BYTES = 512,
    localparam int LIM_W     = $clog2(MAP_BYTES + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bffa_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [bffa_pkg::DATA_W-1:0]   pwdata,
    output logic      [bffa_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output logic      [LIM_W-1:0]              limit
);

    localparam logic [12:0] MAX_BYTES = 13'(MAP_BYTES);

    logic [bffa_pkg::CFG_W-1:0] map_bytes_reg;
    logic [bffa_pkg::CFG_W-1:0] map_bytes_next;
    logic                       wr_hit;
    logic [12:0]                cfg13;
    logic [12:0]                lim13;
    logic [LIM_W+12:0]          lim_ext;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && pready
                    && (paddr[2] == bffa_pkg::REG_MAP_BYTES);

    always_comb
    begin
        map_bytes_next = map_bytes_reg;
        if (wr_hit)
        begin
            map_bytes_next = pwdata[bffa_pkg::CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_bytes_reg <= bffa_pkg::CFG_RESET;
        end
        else
        begin
            map_bytes_reg <= map_bytes_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == bffa_pkg::REG_MAP_BYTES)
        begin
            prdata = {{(bffa_pkg::DATA_W - bffa_pkg::CFG_W){1'b0}}, map_bytes_reg};
        end
    end

    // clamp to the map size
    assign cfg13   = {3'b000, map_bytes_reg};
    assign lim13   = (cfg13 > MAX_BYTES) ? MAX_BYTES : cfg13;
    assign lim_ext = {{LIM_W{1'b0}}, lim13};
    assign limit   = lim_ext[LIM_W-1:0];

endmodule

`default_nettype wire

// ===== sv/bffa_ctrl.sv =====
`default_nettype none

module bffa_ctrl #(
    parameter int  MAP_BYTES = 512,
    localparam int ROWS      = (MAP_BYTES + 7) / 8,
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1,
    localparam int LIM_W     = $clog2(MAP_BYTES + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [LIM_W-1:0]              limit,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire bffa_pkg::in_word_t            in_word,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output bffa_pkg::out_word_t                out_word,
    output logic                               mem_we,
    output logic      [ROW_W-1:0]              mem_waddr,
    output logic      [bffa_pkg::ROW_BITS-1:0] mem_wdata,
    output logic                               mem_re,
    output logic      [ROW_W-1:0]              mem_raddr,
    input  wire logic [bffa_pkg::ROW_BITS-1:0] mem_rdata
);

    bffa_pkg::state_t state_reg, state_next;

    logic [ROW_W-1:0]              row_reg, row_next;
    logic [ROW_W-1:0]              clr_row_reg, clr_row_next;
    logic [5:0]                    pos_reg, pos_next;
    logic                          wr_en_reg, wr_en_next;
    logic [bffa_pkg::ROW_BITS-1:0] wr_data_reg, wr_data_next;
    logic [11:0]                   res_index_reg, res_index_next;
    logic [1:0]                    res_status_reg, res_status_next;
    logic                          out_valid_reg, out_valid_next;
    bffa_pkg::out_word_t           out_word_reg, out_word_next;

    // limit-derived values
    logic [LIM_W-1:0]  lim_m1;
    logic [LIM_W+12:0] lm1_ext;
    logic [LIM_W+12:0] lim_ext;
    logic [ROW_W-1:0]  last_row;
    logic [2:0]        last_byte;
    logic [12:0]       lim13;

    // release decode
    logic [ROW_W+5:0] rr_ext;
    logic [ROW_W-1:0] rel_row;
    logic             range_bad;

    // row search
    logic [7:0]        row_bytes [8];
    logic [7:0]        full_vec;
    logic [2:0]        first_byte;
    logic [2:0]        first_bit;
    logic [5:0]        alloc_pos;
    logic              found;
    logic [ROW_W+17:0] ai_ext;
    logic [11:0]       alloc_index;

    assign lim_m1    = limit - LIM_W'(1);
    assign lm1_ext   = {13'b0, lim_m1};
    assign last_row  = lm1_ext[ROW_W+2:3];
    assign last_byte = lm1_ext[2:0];
    assign lim_ext   = {13'b0, limit};
    assign lim13     = lim_ext[12:0];

    assign rr_ext    = {{ROW_W{1'b0}}, in_word.entry_index[11:6]};
    assign rel_row   = rr_ext[ROW_W-1:0];
    assign range_bad = ({4'b0000, in_word.entry_index[11:3]} >= lim13);

    // bytes past the limit in the last row count as full
    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            row_bytes[j] = mem_rdata[bffa_pkg::ROW_BITS-1-8*j -: 8]
                           | (((row_reg == last_row) && (3'(j) > last_byte))
                              ? bffa_pkg::FULL_BYTE : 8'h00);
            full_vec[7-j] = (row_bytes[j] == bffa_pkg::FULL_BYTE);
        end
    end

    assign found       = (full_vec != bffa_pkg::FULL_BYTE);
    assign first_byte  = bffa_pkg::first_zero8(full_vec);
    assign first_bit   = bffa_pkg::first_zero8(row_bytes[first_byte]);
    assign alloc_pos   = {first_byte, first_bit};
    assign ai_ext      = {12'b0, row_reg, alloc_pos};
    assign alloc_index = ai_ext[11:0];

    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        clr_row_next    = clr_row_reg;
        pos_next        = pos_reg;
        wr_en_next      = wr_en_reg;
        wr_data_next    = wr_data_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        in_stall        = 1'b1;
        mem_re          = 1'b0;
        mem_raddr       = row_reg;
        mem_we          = 1'b0;
        mem_waddr       = row_reg;
        mem_wdata       = wr_data_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            bffa_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_row_reg;
                mem_wdata = '0;
                if (clr_row_reg == ROW_W'(ROWS - 1))
                begin
                    state_next = bffa_pkg::ST_IDLE;
                end
                else
                begin
                    clr_row_next = clr_row_reg + ROW_W'(1);
                end
            end
            bffa_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (in_word.req_type == bffa_pkg::REQ_ALLOC)
                    begin
                        if (limit == '0)
                        begin
                            wr_en_next      = 1'b0;
                            res_index_next  = '0;
                            res_status_next = bffa_pkg::STATUS_FULL;
                            state_next      = bffa_pkg::ST_FINISH;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = '0;
                            row_next   = '0;
                            state_next = bffa_pkg::ST_ALLOC;
                        end
                    end
                    else
                    begin
                        res_index_next = in_word.entry_index;
                        if (range_bad)
                        begin
                            wr_en_next      = 1'b0;
                            res_status_next = bffa_pkg::STATUS_RANGE;
                            state_next      = bffa_pkg::ST_FINISH;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = rel_row;
                            row_next   = rel_row;
                            pos_next   = in_word.entry_index[5:0];
                            state_next = bffa_pkg::ST_RELEASE;
                        end
                    end
                end
            end
            bffa_pkg::ST_ALLOC:
            begin
                if (found)
                begin
                    wr_en_next      = 1'b1;
                    wr_data_next    = mem_rdata | (bffa_pkg::ROW_TOP_BIT >> alloc_pos);
                    res_index_next  = alloc_index;
                    res_status_next = bffa_pkg::STATUS_OK;
                    state_next      = bffa_pkg::ST_FINISH;
                end
                else if (row_reg == last_row)
                begin
                    wr_en_next      = 1'b0;
                    res_index_next  = '0;
                    res_status_next = bffa_pkg::STATUS_FULL;
                    state_next      = bffa_pkg::ST_FINISH;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = row_reg + ROW_W'(1);
                    row_next  = row_reg + ROW_W'(1);
                end
            end
            bffa_pkg::ST_RELEASE:
            begin
                wr_en_next      = 1'b1;
                wr_data_next    = mem_rdata & ~(bffa_pkg::ROW_TOP_BIT >> pos_reg);
                res_status_next = bffa_pkg::STATUS_OK;
                state_next      = bffa_pkg::ST_FINISH;
            end
            bffa_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    mem_we                     = wr_en_reg;
                    out_valid_next             = 1'b1;
                    out_word_next.result_index = res_index_reg;
                    out_word_next.status       = res_status_reg;
                    state_next                 = bffa_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bffa_pkg::ST_CLEAR;
            clr_row_reg   <= '0;
            out_valid_reg <= 1'b0;
            wr_en_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_row_reg   <= clr_row_next;
            out_valid_reg <= out_valid_next;
            wr_en_reg     <= wr_en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        pos_reg        <= pos_next;
        wr_data_reg    <= wr_data_next;
        res_index_reg  <= res_index_next;
        res_status_reg <= res_status_next;
        out_word_reg   <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

`default_nettype wire

// ===== sv/bitmap_first_free_allocator_core.sv =====
// bitmap allocator: hands out the lowest free entry and takes entries back
// input channel (in_valid / in_stall / in_word): one word per request,
//   req_type 0 allocates the first free entry, 1 releases entry_index
// output channel (out_valid / out_stall / out_word): exactly one word per
//   request, result_index plus status (ok, no free entry, release out of range)
// apb port: register 0 at address 0 sets how many map bytes are in use,
//   clamped to MAP_BYTES; write it only while no request is in flight
// the map lives in one synchronous ram of 64-bit rows (eight map bytes each);
//   an allocate reads one row a cycle and does the first-zero search on it
// throughput is one request at a time:
//   an allocate reads rows from the first until one has a free bit or the
//   last row in use is reached; a release reads its row and clears the bit;
//   a release out of range or an allocate with zero bytes in use skips the map
// the result register sits between the scan and the receiver, so a stalled
//   receiver holds the result word while the next request is accepted; the
//   following result waits until that word has been taken
// reset clears the map by writing zero to every row, with in_stall high;
//   the apb port works meanwhile
`default_nettype none

module bitmap_first_free_allocator_core #(
    parameter int MAP_BYTES = 512
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bffa_pkg::ADDR_W-1:0] paddr,
    input  wire logic [bffa_pkg::DATA_W-1:0] pwdata,
    output logic      [bffa_pkg::DATA_W-1:0] prdata,
    output logic                             pready,

    // request channel
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire bffa_pkg::in_word_t          in_word,

    // result channel
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output bffa_pkg::out_word_t              out_word
);

    // one ram row holds eight map bytes
    localparam int ROWS  = (MAP_BYTES + 7) / 8;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LIM_W = $clog2(MAP_BYTES + 1);

    logic [LIM_W-1:0]              limit;
    logic                          mem_we;
    logic [ROW_W-1:0]              mem_waddr;
    logic [bffa_pkg::ROW_BITS-1:0] mem_wdata;
    logic                          mem_re;
    logic [ROW_W-1:0]              mem_raddr;
    logic [bffa_pkg::ROW_BITS-1:0] mem_rdata;

    // map size register, clamped to the physical map
    bffa_cfg #(
        .MAP_BYTES (MAP_BYTES)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .limit   (limit)
    );

    // sequencer: clear sweep, row scan, read-modify-write, result register
    bffa_ctrl #(
        .MAP_BYTES (MAP_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .limit     (limit),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // usage map storage with a registered read port
    bffa_ram #(
        .DEPTH (ROWS),
        .AW    (ROW_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

endmodule

`default_nettype wire

// ===== sv/bffa_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module bffa_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire bffa_pkg::out_word_t out_word
);

    // a stalled result word stays put
    `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "result word changed while stalled")

    // one request at a time: intake closes right after an accept
    `CHK_NEXT(a_in_close, in_valid && !in_stall, in_stall, "request accepted while busy")

    // a new result only follows a cycle with intake closed
    `CHK_IMPLY(a_out_src, $rose(out_valid), $past(in_stall), "result without a request in flight")

    // a full map reports index zero
    `CHK_IMPLY(a_full_idx, out_valid && (out_word.status == bffa_pkg::STATUS_FULL), out_word.result_index == 12'd0, "full status with nonzero index")

endmodule

bind bitmap_first_free_allocator_core bffa_checker u_bffa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);

`default_nettype wire
